// File: rtl/core/pgf_pkg.sv
// Shared types and constants for the pairwise gravity force engine.
// Holds the controller/datapath command and status structs and the saturating add.
// No dependencies.
package pgf_pkg;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 192;
    localparam int RES_W      = 48;

    localparam logic [2:0] REG_BODY_COUNT = 3'd0;
    localparam logic [2:0] REG_SOFTENING  = 3'd1;
    localparam logic [2:0] REG_GRAVITY    = 3'd2;
    localparam logic [2:0] REG_DECIMATION = 3'd3;
    localparam logic [2:0] REG_PHASE      = 3'd4;

    localparam logic [62:0] LIM63 = {63{1'b1}};

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_MOD, OP_LDIV, OP_OFF, OP_RD, OP_DIFF, OP_SQ,
        OP_SQRT_INIT, OP_SQRT, OP_RDMUL, OP_DINIT, OP_DIV, OP_ACC, OP_NEXT,
        OP_FINIT, OP_FMUL, OP_FEND, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] k;    // component: 0..2 force axes, 3 potential
        logic [1:0] sub;  // partial product index
    } t_cmd;

    typedef struct packed {
        logic       mod_done;
        logic       j_done;
        logic       skip;
        logic [3:0] mag_zero;
        logic       out_busy;
    } t_stat;

    // Signed 64-bit add of a magnitude, clamped at +-(2^63-1); top bit flags a clamp.
    function automatic logic [64:0] sat_add(input logic [63:0] acc, input logic neg,
                                            input logic [62:0] mag);
        logic [65:0] a;
        logic [65:0] b;
        logic [65:0] s;
        a = {{2{acc[63]}}, acc};
        b = {3'b000, mag};
        s = neg ? (a - b) : (a + b);
        if ($signed(s) > $signed({3'b000, LIM63})) begin
            return {1'b1, 1'b0, LIM63};
        end else if ($signed(s) < -$signed({3'b000, LIM63})) begin
            return {1'b1, 64'h8000_0000_0000_0001};
        end
        return {1'b0, s[63:0]};
    endfunction

endpackage

// File: rtl/core/pgf_dp.sv
// Datapath of the gravity engine: body table, config registers, pair arithmetic.
// Steered by pgf_ctrl through t_cmd; depends on pgf_pkg.
module pgf_dp #(
    parameter int MAX_BODIES     = 1024,
    parameter int MAX_DECIMATION = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_take,
    input  logic [pgf_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    input  pgf_pkg::t_cmd                      i_cmd,
    output pgf_pkg::t_stat                     o_stat,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [pgf_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic                               o_out_sat
);
    import pgf_pkg::*;

    localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam int NW    = (CNT_W > 11) ? CNT_W : 11;
    localparam int DW    = $clog2(MAX_DECIMATION + 1);

    // configuration
    logic [10:0] r_body_count;
    logic [31:0] r_soft;
    logic [31:0] r_grav;
    logic [4:0]  r_decim;
    logic [3:0]  r_phase;

    // captured beat
    logic [9:0]  r_slot;
    logic [31:0] r_pos [3];
    logic [31:0] r_mi;

    logic [127:0] mem [MAX_BODIES];
    logic [127:0] r_rdata;

    logic [DW-1:0] r_dec;
    logic [3:0]    r_pm;
    logic [NW-1:0] r_lq;
    logic [DW:0]   r_lrem;
    logic [NW-1:0] r_j;
    logic [NW-1:0] r_end;

    logic [32:0]  r_mag [3];
    logic [2:0]   r_neg;
    logic [31:0]  r_mj;
    logic [67:0]  r_d;
    logic [67:0]  r_sd;
    logic [35:0]  r_srem;
    logic [33:0]  r_root;
    logic [99:0]  r_rd;
    logic [103:0] r_num;
    logic [99:0]  r_den;
    logic [99:0]  r_drem;
    logic [63:0]  r_sum [3];
    logic [63:0]  r_psum;
    logic         r_sat;
    logic [63:0]  r_p;
    logic         r_fneg;
    logic         r_fzero;
    logic [62:0]  r_fmag;
    logic [127:0] r_w;
    logic [47:0]  r_res [4];
    logic         r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic         r_out_sat;

    logic [NW-1:0] n_count;
    logic [DW-1:0] n_dec;
    logic          slot_ok;
    logic [32:0]   sel_mag;
    logic          sel_neg;
    logic [63:0]   sel_sum;
    logic [DW:0]   lrem_s;
    logic [37:0]   srem_s;
    logic [37:0]   trial;
    logic [100:0]  drem_s;
    logic [23:0]   dpart;
    logic [57:0]   rd_pp;
    logic [64:0]   mm;
    logic [62:0]   qc;
    logic          qsat;
    logic [64:0]   add_res;
    logic [31:0]  fa;
    logic [31:0]  fb;
    logic [63:0]  f_pp;
    logic [127:0] ws;
    logic [47:0]  lim48;
    logic [56:0]  mdec;
    logic         f_over;
    logic [47:0]  f_mag;
    logic [32:0]  dv [3];
    logic [65:0]  sq;

    always_comb begin
        if (32'(r_body_count) > 32'(MAX_BODIES)) begin
            n_count = NW'(MAX_BODIES);
        end else begin
            n_count = NW'(r_body_count);
        end
        if (r_decim == 5'd0) begin
            n_dec = DW'(1);
        end else if (32'(r_decim) > 32'(MAX_DECIMATION)) begin
            n_dec = DW'(MAX_DECIMATION);
        end else begin
            n_dec = DW'(r_decim);
        end
        slot_ok = 32'(r_slot) < 32'(MAX_BODIES);

        case (i_cmd.k)
            2'd0:    begin sel_mag = r_mag[0]; sel_neg = r_neg[0]; sel_sum = r_sum[0]; end
            2'd1:    begin sel_mag = r_mag[1]; sel_neg = r_neg[1]; sel_sum = r_sum[1]; end
            2'd2:    begin sel_mag = r_mag[2]; sel_neg = r_neg[2]; sel_sum = r_sum[2]; end
            default: begin sel_mag = r_mag[2]; sel_neg = 1'b0;     sel_sum = r_psum;   end
        endcase

        for (int k = 0; k < 3; k++) begin
            dv[k] = {r_pos[k][31], r_pos[k]} - {r_rdata[32*k+31], r_rdata[32*k +: 32]};
        end
        sq = 66'(sel_mag) * 66'(sel_mag);

        lrem_s = {r_lrem[DW-1:0], r_lq[NW-1]};
        srem_s = {r_srem, r_sd[67:66]};
        trial  = {2'b00, r_root, 2'b01};
        drem_s = {r_drem, r_num[103]};

        case (i_cmd.sub)
            2'd0:    dpart = r_d[23:0];
            2'd1:    dpart = r_d[47:24];
            default: dpart = {4'b0000, r_d[67:48]};
        endcase
        rd_pp = 58'(dpart) * 58'(r_root);
        mm    = 65'(r_mj) * 65'(sel_mag);

        qsat = |r_num[103:63];
        qc   = qsat ? LIM63 : r_num[62:0];
        add_res = sat_add(sel_sum, sel_neg, qc);

        fa   = i_cmd.sub[1] ? r_p[63:32] : r_p[31:0];
        fb   = i_cmd.sub[0] ? {1'b0, r_fmag[62:32]} : r_fmag[31:0];
        f_pp = 64'(fa) * 64'(fb);

        ws     = (i_cmd.k == 2'd3) ? (r_w >> 16) : (r_w >> 32);
        lim48  = r_fneg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        mdec   = 57'(ws[47:0]) * 57'(r_dec);
        f_over = (ws > {80'b0, lim48}) || (mdec > 57'(lim48));
        f_mag  = f_over ? lim48 : mdec[47:0];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_count <= '0;
            r_soft       <= '0;
            r_grav       <= 32'd65536;
            r_decim      <= 5'd1;
            r_phase      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BODY_COUNT: r_body_count <= i_cfg_data[10:0];
                REG_SOFTENING:  r_soft       <= i_cfg_data;
                REG_GRAVITY:    r_grav       <= i_cfg_data;
                REG_DECIMATION: r_decim      <= i_cfg_data[4:0];
                REG_PHASE:      r_phase      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // body table
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && slot_ok) begin
            mem[IDX_W'(r_slot)] <= {r_mi, r_pos[2], r_pos[1], r_pos[0]};
        end
        if (i_cmd.op == OP_RD) begin
            r_rdata <= mem[IDX_W'(r_j)];
        end
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_slot   <= i_in_data[9:0];
            r_pos[0] <= i_in_data[41:10];
            r_pos[1] <= i_in_data[73:42];
            r_pos[2] <= i_in_data[105:74];
            r_mi     <= i_in_data[137:106];
        end
        unique case (i_cmd.op)
            OP_INIT: begin
                r_dec  <= n_dec;
                r_pm   <= r_phase;
                r_lq   <= n_count;
                r_lrem <= '0;
                r_sum[0] <= '0;
                r_sum[1] <= '0;
                r_sum[2] <= '0;
                r_psum <= '0;
                r_sat  <= 1'b0;
            end
            OP_MOD: begin
                if (32'(r_pm) >= 32'(r_dec)) begin
                    r_pm <= 4'(32'(r_pm) - 32'(r_dec));
                end
            end
            OP_LDIV: begin
                if (lrem_s >= {1'b0, r_dec}) begin
                    r_lrem <= lrem_s - {1'b0, r_dec};
                    r_lq   <= {r_lq[NW-2:0], 1'b1};
                end else begin
                    r_lrem <= lrem_s;
                    r_lq   <= {r_lq[NW-2:0], 1'b0};
                end
            end
            OP_OFF: begin
                r_j   <= NW'(r_pm * r_lq);
                r_end <= NW'(r_pm * r_lq) + r_lq;
            end
            OP_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= dv[k][32];
                    r_mag[k] <= dv[k][32] ? (33'd0 - dv[k]) : dv[k];
                end
                r_mj <= r_rdata[127:96];
                r_d  <= {20'b0, r_soft, 16'b0};
            end
            OP_SQ: begin
                r_d <= r_d + 68'(sq);
            end
            OP_SQRT_INIT: begin
                r_sd   <= r_d;
                r_srem <= '0;
                r_root <= '0;
                r_rd   <= '0;
            end
            OP_SQRT: begin
                r_sd <= {r_sd[65:0], 2'b00};
                if (srem_s >= trial) begin
                    r_srem <= 36'(srem_s - trial);
                    r_root <= {r_root[32:0], 1'b1};
                end else begin
                    r_srem <= srem_s[35:0];
                    r_root <= {r_root[32:0], 1'b0};
                end
            end
            OP_RDMUL: begin
                case (i_cmd.sub)
                    2'd0:    r_rd <= r_rd + {42'b0, rd_pp};
                    2'd1:    r_rd <= r_rd + {18'b0, rd_pp, 24'b0};
                    default: r_rd <= r_rd + {rd_pp[51:0], 48'b0};
                endcase
            end
            OP_DINIT: begin
                r_drem <= '0;
                if (i_cmd.k == 2'd3) begin
                    r_num <= {48'b0, r_mj, 24'b0};
                    r_den <= {66'b0, r_root};
                end else begin
                    r_num <= {mm[63:0], 40'b0};
                    r_den <= r_rd;
                end
            end
            OP_DIV: begin
                if (drem_s >= {1'b0, r_den}) begin
                    r_drem <= 100'(drem_s - {1'b0, r_den});
                    r_num  <= {r_num[102:0], 1'b1};
                end else begin
                    r_drem <= drem_s[99:0];
                    r_num  <= {r_num[102:0], 1'b0};
                end
            end
            OP_ACC: begin
                r_sat <= r_sat | qsat | add_res[64];
                case (i_cmd.k)
                    2'd0:    r_sum[0] <= add_res[63:0];
                    2'd1:    r_sum[1] <= add_res[63:0];
                    2'd2:    r_sum[2] <= add_res[63:0];
                    default: r_psum   <= add_res[63:0];
                endcase
            end
            OP_NEXT: begin
                r_j <= r_j + 1'b1;
            end
            OP_FINIT: begin
                r_p     <= (i_cmd.k == 2'd3) ? {32'b0, r_grav} : 64'(r_grav) * 64'(r_mi);
                r_fneg  <= $signed(sel_sum) > 0;
                r_fzero <= sel_sum == 64'd0;
                r_fmag  <= sel_sum[63] ? 63'(64'd0 - sel_sum) : sel_sum[62:0];
                r_w     <= '0;
            end
            OP_FMUL: begin
                case (i_cmd.sub)
                    2'd0:    r_w <= r_w + {64'b0, f_pp};
                    2'd3:    r_w <= r_w + {f_pp, 64'b0};
                    default: r_w <= r_w + {32'b0, f_pp, 32'b0};
                endcase
            end
            OP_FEND: begin
                r_sat <= r_sat | (!r_fzero && f_over);
                if (r_fzero) begin
                    r_res[i_cmd.k] <= '0;
                end else begin
                    r_res[i_cmd.k] <= r_fneg ? (48'd0 - f_mag) : f_mag;
                end
            end
            OP_OUT: begin
                r_out_data <= {r_res[3], r_res[2], r_res[1], r_res[0]};
                r_out_sat  <= r_sat;
            end
            default: ;
        endcase
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.mod_done = 32'(r_pm) < 32'(r_dec);
        o_stat.j_done   = r_j >= r_end;
        o_stat.skip     = (r_d == 68'd0) || (r_mj == 32'd0);
        o_stat.mag_zero = {1'b0, r_mag[2] == 33'd0, r_mag[1] == 33'd0, r_mag[0] == 33'd0};
        o_stat.out_busy = r_out_valid & ~i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_sat   = r_out_sat;

endmodule

// File: rtl/core/pgf_ctrl.sv
// Sequencer of the gravity engine: walks the slice, pairs and final scaling.
// Drives pgf_dp through t_cmd and reads t_stat; depends on pgf_pkg.
module pgf_ctrl #(
    parameter int MAX_BODIES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic           i_kind,
    input  pgf_pkg::t_stat i_stat,
    output pgf_pkg::t_cmd  o_cmd,
    output logic           o_ready
);
    import pgf_pkg::*;

    localparam int CNT_W = $clog2(MAX_BODIES + 1);
    localparam int NW    = (CNT_W > 11) ? CNT_W : 11;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_INIT, S_MOD, S_LDIV, S_OFF, S_CHK, S_RD, S_DIFF, S_SQ,
        S_SQRT0, S_SQRT, S_RDMUL, S_DINIT, S_DIV, S_ACC, S_NEXT, S_FINIT, S_FMUL,
        S_FEND, S_OUT
    } t_state;

    t_state     r_state;
    logic [6:0] r_cnt;
    logic [1:0] r_k;
    logic [1:0] r_sub;
    logic       r_ready;

    always_comb begin
        o_cmd.k   = r_k;
        o_cmd.sub = r_sub;
        unique case (r_state)
            S_LOAD:  o_cmd.op = OP_LOAD;
            S_INIT:  o_cmd.op = OP_INIT;
            S_MOD:   o_cmd.op = OP_MOD;
            S_LDIV:  o_cmd.op = OP_LDIV;
            S_OFF:   o_cmd.op = OP_OFF;
            S_RD:    o_cmd.op = OP_RD;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_SQ:    o_cmd.op = OP_SQ;
            S_SQRT0: o_cmd.op = OP_SQRT_INIT;
            S_SQRT:  o_cmd.op = OP_SQRT;
            S_RDMUL: o_cmd.op = OP_RDMUL;
            S_DINIT: o_cmd.op = i_stat.mag_zero[r_k] ? OP_NONE : OP_DINIT;
            S_DIV:   o_cmd.op = OP_DIV;
            S_ACC:   o_cmd.op = OP_ACC;
            S_NEXT:  o_cmd.op = OP_NEXT;
            S_FINIT: o_cmd.op = OP_FINIT;
            S_FMUL:  o_cmd.op = OP_FMUL;
            S_FEND:  o_cmd.op = OP_FEND;
            S_OUT:   o_cmd.op = i_stat.out_busy ? OP_NONE : OP_OUT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_sub   <= '0;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_take) begin
                        r_ready <= 1'b0;
                        r_state <= i_kind ? S_INIT : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_ready <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_INIT: r_state <= S_MOD;
                S_MOD: begin
                    if (i_stat.mod_done) begin
                        r_cnt   <= 7'(NW - 1);
                        r_state <= S_LDIV;
                    end
                end
                S_LDIV: begin
                    if (r_cnt == 7'd0) r_state <= S_OFF;
                    else r_cnt <= r_cnt - 1'b1;
                end
                S_OFF: r_state <= S_CHK;
                S_CHK: begin
                    r_k     <= '0;
                    r_state <= i_stat.j_done ? S_FINIT : S_RD;
                end
                S_RD:   r_state <= S_DIFF;
                S_DIFF: r_state <= S_SQ;
                S_SQ: begin
                    if (r_k == 2'd2) r_state <= S_SQRT0;
                    else r_k <= r_k + 1'b1;
                end
                S_SQRT0: begin
                    r_cnt   <= 7'd33;
                    r_state <= i_stat.skip ? S_NEXT : S_SQRT;
                end
                S_SQRT: begin
                    r_sub <= '0;
                    if (r_cnt == 7'd0) r_state <= S_RDMUL;
                    else r_cnt <= r_cnt - 1'b1;
                end
                S_RDMUL: begin
                    if (r_sub == 2'd2) begin
                        r_k     <= 2'd3;
                        r_state <= S_DINIT;
                    end else begin
                        r_sub <= r_sub + 1'b1;
                    end
                end
                S_DINIT, S_ACC: begin
                    if (r_state == S_DINIT && !i_stat.mag_zero[r_k]) begin
                        r_cnt   <= 7'd103;
                        r_state <= S_DIV;
                    end else if (r_k == 2'd3) begin
                        // potential done first, then the three axes
                        r_k     <= 2'd0;
                        r_state <= S_DINIT;
                    end else if (r_k == 2'd2) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DINIT;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd0) r_state <= S_ACC;
                    else r_cnt <= r_cnt - 1'b1;
                end
                S_NEXT: r_state <= S_CHK;
                S_FINIT: begin
                    r_sub   <= '0;
                    r_state <= S_FMUL;
                end
                S_FMUL: begin
                    if (r_sub == 2'd3) r_state <= S_FEND;
                    else r_sub <= r_sub + 1'b1;
                end
                S_FEND: begin
                    if (r_k == 2'd3) begin
                        r_state <= S_OUT;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_FINIT;
                    end
                end
                S_OUT: begin
                    if (!i_stat.out_busy) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = r_ready;

endmodule

// File: rtl/core/pairwise_gravity_force_engine.sv
// Top level of the direct N-body gravity force engine.
// Instantiates pgf_ctrl (sequencer) and pgf_dp (table and arithmetic); uses pgf_pkg.
//
// Channel   Dir  Handshake                Payload
// s_axis    in   tvalid/tready            tuser: operation; tdata: slot, pos_x/y/z, mass
// m_axis    out  tvalid/tready            tuser: saturated; tdata: acc_x/y/z, potential
// cfg       in   i_cfg_we (no wait)       i_cfg_index, i_cfg_data
//
// A load beat writes its body to the table. A compute beat runs slice setup (the
// phase is reduced by repeated subtraction, one step per cycle), visits each body of
// the slice, skipping a body of zero mass, or of zero distance under zero softening,
// and each zero axis, then does the final scaling and output; the per-body work is
// set by the bit-serial divider, one quotient bit per cycle, 104 bits for each of
// the potential and three force terms. Reset is synchronous, active low, and leaves
// the table undefined. The result register holds its beat under m_axis_tready low
// while the next input beat is already taken; a further compute waits at its output.
module pairwise_gravity_force_engine #(
    parameter int MAX_BODIES     = 1024,
    parameter int MAX_DECIMATION = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic                              s_axis_tuser,   // operation
    // slot[9:0], pos_x[41:10], pos_y[73:42], pos_z[105:74], body_mass[137:106], zero pad
    input  logic [pgf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic                              m_axis_tuser,   // saturated
    // acc_x[47:0], acc_y[95:48], acc_z[143:96], potential[191:144]
    output logic [pgf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);
    import pgf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  take;

    // a beat enters when both sides agree
    assign take = s_axis_tvalid & s_axis_tready;

    pgf_ctrl #(
        .MAX_BODIES(MAX_BODIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_kind  (s_axis_tuser),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (s_axis_tready)
    );

    pgf_dp #(
        .MAX_BODIES    (MAX_BODIES),
        .MAX_DECIMATION(MAX_DECIMATION)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_sat   (m_axis_tuser)
    );

endmodule

// File: rtl/core/pgf_checker.sv
// Port-level checks for the gravity engine, bound to the top level.
// Depends only on the top level's ports.
module pgf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic s_axis_tuser,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    // hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // drop ready after every accepted beat
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat taken while busy");

    // a load passes through the load state and returns to idle
    a_load_turnaround: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> ##1 s_axis_tready)
        else $error("load did not finish in two cycles");

    // a new result appears together with the return to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result presented while still computing");
endmodule

bind pairwise_gravity_force_engine pgf_checker u_pgf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
